// ===== sv/hmq_pkg.sv =====
// Shared constants, types and codes for the binary max-heap queue.
`timescale 1ns / 1ps
`default_nettype none
package hmq_pkg;

  localparam int DEPTH   = 1024;
  localparam int KEY_W   = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_LAST,
    S_DN,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

// ===== sv/hmq_in_if.sv =====
// Input channel: operation kind and key, with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface hmq_in_if import hmq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

// ===== sv/hmq_out_if.sv =====
// Result channel: removed key, new top, count and status, with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface hmq_out_if import hmq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] removed_value;
  logic [VALUE_W-1:0] top_value;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;
  logic [1:0]         status;

  modport source (output valid, output removed_value, output top_value,
                  output entry_count, output is_empty, output status, input ready);
  modport sink   (input valid, input removed_value, input top_value,
                  input entry_count, input is_empty, input status, output ready);
endinterface
`default_nettype wire

// ===== sv/hmq_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output      logic [WIDTH-1:0] rdata_a,
  output      logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== sv/binary_max_heap_queue.sv =====
// Top level of the binary max-heap priority queue.
//
// Each input transaction is an insert (kind 0) or a remove-max (kind 1) and
// gives exactly one result transaction. The keys live in a RAM with one write
// port and two registered read ports; the root is also kept in a register, so
// the removed value and the new top never need a RAM read. A sift moves a
// "hole" one level per cycle: the read ports fetch the parent (sift-up) or both
// children (sift-down) while the write port stores the level just settled.
// An insert climbs k levels (0..10 at 1024 entries) before its result is
// formed; a remove moves the last entry to the root and then descends k levels,
// or skips the sift when it empties the heap; flagged operations skip it too.
// The input is ready whenever no operation is in progress, also while a result
// waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module binary_max_heap_queue import hmq_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  hmq_in_if.sink   in_ch,
  hmq_out_if.source out_ch
);

  state_t  state_r, state_nxt;
  addr_t   pos_r, pos_nxt;
  key_t    key_r, key_nxt;
  cnt_t    cnt_r, cnt_nxt;
  key_t    top_r, top_nxt;
  key_t    removed_r, removed_nxt;
  status_t status_r, status_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_removed_r, out_removed_nxt;
  logic [VALUE_W-1:0] out_top_r, out_top_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic               out_empty_r, out_empty_nxt;
  status_t            out_status_r, out_status_nxt;

  logic  ram_we;
  addr_t ram_waddr;
  key_t  ram_wdata;
  addr_t ram_raddr_a, ram_raddr_b;
  key_t  ram_rdata_a, ram_rdata_b;

  hmq_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // Handshake and shared decisions
  logic in_fire, out_slot_free, heap_full, heap_empty;
  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_slot_free = !out_valid_r || out_ch.ready;
  assign heap_full     = (cnt_r == CNT_W'(DEPTH));
  assign heap_empty    = (cnt_r == '0);

  // Sift-up: rdata_a holds the parent of pos_r
  addr_t up_parent;
  logic  up_at_root, up_swap;
  assign up_parent  = (pos_r - addr_t'(1)) >> 1;
  assign up_at_root = (pos_r == '0);
  assign up_swap    = !up_at_root && (ram_rdata_a < key_r);

  // Sift-down: rdata_a holds the left child, rdata_b the right child
  logic [CNT_W:0] lft_idx, rgt_idx;
  logic           lft_ok, rgt_ok;
  logic           dn_move, dn_right_win, dn_left_win;
  key_t           dn_best;
  addr_t          dn_child, dn_cpos;
  assign lft_idx = {1'b0, pos_r, 1'b1};
  assign rgt_idx = {1'b0, pos_r, 1'b0} + (CNT_W + 1)'(2);
  assign lft_ok  = lft_idx < {1'b0, cnt_r};
  assign rgt_ok  = rgt_idx < {1'b0, cnt_r};

  always_comb begin
    dn_best      = key_r;
    dn_right_win = 1'b0;
    dn_left_win  = 1'b0;
    if (rgt_ok && (dn_best < ram_rdata_b)) begin
      dn_best      = ram_rdata_b;
      dn_right_win = 1'b1;
    end
    if (lft_ok && (dn_best < ram_rdata_a)) begin
      dn_best      = ram_rdata_a;
      dn_right_win = 1'b0;
      dn_left_win  = 1'b1;
    end
  end

  assign dn_move  = dn_right_win || dn_left_win;
  assign dn_child = dn_left_win ? lft_idx[ADDR_W-1:0] : rgt_idx[ADDR_W-1:0];
  assign dn_cpos  = dn_move ? dn_child : pos_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == KIND_INSERT) begin
            state_nxt = heap_full ? S_RESP : S_UP;
          end else if (heap_empty || (cnt_r == cnt_t'(1))) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_DN_LAST;
          end
        end
      end
      S_UP: begin
        if (!up_swap) begin
          state_nxt = S_RESP;
        end
      end
      S_DN_LAST: state_nxt = S_DN;
      S_DN: begin
        if (!dn_move) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM control and result register
  always_comb begin
    pos_nxt         = pos_r;
    key_nxt         = key_r;
    cnt_nxt         = cnt_r;
    top_nxt         = top_r;
    removed_nxt     = removed_r;
    status_nxt      = status_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_r;
    ram_wdata       = key_r;
    ram_raddr_a     = up_parent;
    ram_raddr_b     = up_parent;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_removed_nxt = out_removed_r;
    out_top_nxt     = out_top_r;
    out_cnt_nxt     = out_cnt_r;
    out_empty_nxt   = out_empty_r;
    out_status_nxt  = out_status_r;
    case (state_r)
      S_IDLE: begin
        removed_nxt = '0;
        status_nxt  = STAT_OK;
        if (in_ch.kind == KIND_INSERT) begin
          // fetch the parent of the new last slot
          ram_raddr_a = (cnt_r[ADDR_W-1:0] - addr_t'(1)) >> 1;
        end else begin
          // fetch the last entry, which moves to the root
          ram_raddr_a = cnt_r[ADDR_W-1:0] - addr_t'(1);
        end
        if (in_fire) begin
          if (in_ch.kind == KIND_INSERT) begin
            if (heap_full) begin
              status_nxt = STAT_FULL;
            end else begin
              pos_nxt = cnt_r[ADDR_W-1:0];
              key_nxt = in_ch.value[KEY_W-1:0];
              cnt_nxt = cnt_r + cnt_t'(1);
            end
          end else if (heap_empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            removed_nxt = top_r;
            cnt_nxt     = cnt_r - cnt_t'(1);
          end
        end
      end
      S_UP: begin
        ram_we      = 1'b1;
        ram_wdata   = up_swap ? ram_rdata_a : key_r;
        ram_raddr_a = (up_parent - addr_t'(1)) >> 1;
        if (up_at_root) begin
          top_nxt = key_r;
        end
        if (up_swap) begin
          pos_nxt = up_parent;
        end
      end
      S_DN_LAST: begin
        key_nxt     = ram_rdata_a;
        pos_nxt     = '0;
        ram_raddr_a = addr_t'(1);
        ram_raddr_b = addr_t'(2);
      end
      S_DN: begin
        ram_we      = 1'b1;
        ram_wdata   = dn_best;
        ram_raddr_a = {dn_cpos[ADDR_W-2:0], 1'b1};
        ram_raddr_b = {dn_cpos[ADDR_W-2:0], 1'b0} + addr_t'(2);
        if (pos_r == '0) begin
          top_nxt = dn_best;
        end
        pos_nxt = dn_cpos;
      end
      S_RESP: begin
        if (out_slot_free) begin
          out_valid_nxt   = 1'b1;
          out_removed_nxt = VALUE_W'(removed_r);
          out_top_nxt     = heap_empty ? '0 : VALUE_W'(top_r);
          out_cnt_nxt     = COUNT_W'(cnt_r);
          out_empty_nxt   = heap_empty;
          out_status_nxt  = status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    key_r         <= key_nxt;
    top_r         <= top_nxt;
    removed_r     <= removed_nxt;
    status_r      <= status_nxt;
    out_removed_r <= out_removed_nxt;
    out_top_r     <= out_top_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_empty_r   <= out_empty_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.top_value     = out_top_r;
  assign out_ch.entry_count   = out_cnt_r;
  assign out_ch.is_empty      = out_empty_r;
  assign out_ch.status        = out_status_r;

endmodule
`default_nettype wire
